// ----- design/tcte_pkg.sv -----
// tcte_pkg: shared codes, result word types and helpers for the transfer engine.
// Used by tcte_fsm, tcte_out_slot and tftp_client_transfer_engine.
// Depends on nothing.
`default_nettype none

package tcte_pkg;

    // Input event codes
    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_DATA    = 3'd1;
    localparam logic [2:0] OP_ACK     = 3'd2;
    localparam logic [2:0] OP_TIMEOUT = 3'd3;
    localparam logic [2:0] OP_SOCKERR = 3'd4;
    localparam logic [2:0] OP_CHUNK   = 3'd5;

    // Result action codes
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_ACK      = 3'd1;
    localparam logic [2:0] ACT_DATA     = 3'd2;
    localparam logic [2:0] ACT_DELIVER  = 3'd3;
    localparam logic [2:0] ACT_ERROR    = 3'd4;
    localparam logic [2:0] ACT_FINISHED = 3'd5;
    localparam logic [2:0] ACT_FAILED   = 3'd6;

    // Outcome codes
    localparam logic [1:0] OUT_NONE    = 2'd0;
    localparam logic [1:0] OUT_RETRIES = 2'd1;
    localparam logic [1:0] OUT_BADACK0 = 2'd2;
    localparam logic [1:0] OUT_SOCKERR = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_DIRECTION  = 2'd0;
    localparam logic [1:0] CFG_MAX_RETRY  = 2'd1;
    localparam logic [1:0] CFG_FULL_BYTES = 2'd2;

    // Configuration reset values
    localparam logic        DIRECTION_RST  = 1'b0;
    localparam logic [3:0]  MAX_RETRY_RST  = 4'd5;
    localparam logic [15:0] FULL_BYTES_RST = 16'd512;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] blk;
        logic [15:0] len;
        logic [1:0]  outcome;
    } result_t;

    // Up to three result words caused by one event, count is 1..3
    typedef struct packed {
        result_t [2:0] res;
        logic [1:0]    count;
    } batch_t;

    function automatic result_t make_result(
        input logic [2:0]  action,
        input logic [15:0] blk,
        input logic [15:0] len,
        input logic [1:0]  outcome
    );
        result_t r;
        r.action  = action;
        r.blk     = blk;
        r.len     = len;
        r.outcome = outcome;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/tcte_fsm.sv -----
// tcte_fsm: transfer state and the per-event update that builds a batch of results.
// Depends on tcte_pkg.
`default_nettype none

module tcte_fsm (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [2:0]       op,
    input  wire logic [15:0]      blk,
    input  wire logic [15:0]      len,
    input  wire logic             direction,
    input  wire logic [3:0]       max_retries,
    input  wire logic [15:0]      full_block_bytes,
    output tcte_pkg::batch_t      batch
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DL_RECV,
        PH_UL_ACK0,
        PH_UL_CHUNK,
        PH_UL_ACK,
        PH_DONE,
        PH_FAILED
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] current_block_reg, current_block_next;
    logic [3:0]  retries_left_reg, retries_left_next;
    logic        resend_enable_reg, resend_enable_next;
    logic        chunk_is_full_reg, chunk_is_full_next;
    logic [15:0] chunk_length_reg, chunk_length_next;

    logic [3:0]  reload;
    logic [3:0]  retries_dec;
    logic [15:0] prev_block;
    logic [15:0] next_block;

    assign reload      = (max_retries == 4'd0) ? 4'd1 : max_retries;
    assign retries_dec = retries_left_reg - 4'd1;
    assign prev_block  = current_block_reg - 16'd1;
    assign next_block  = current_block_reg + 16'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        current_block_next = current_block_reg;
        retries_left_next  = retries_left_reg;
        resend_enable_next = resend_enable_reg;
        chunk_is_full_next = chunk_is_full_reg;
        chunk_length_next  = chunk_length_reg;
        batch              = '0;
        batch.count        = 2'd1;
        batch.res[0]       = tcte_pkg::make_result(tcte_pkg::ACT_NONE, 16'd0, 16'd0,
                                                   tcte_pkg::OUT_NONE);

        if (op == tcte_pkg::OP_START)
        begin
            current_block_next = 16'd0;
            resend_enable_next = 1'b1;
            chunk_is_full_next = 1'b1;
            chunk_length_next  = 16'd0;
            retries_left_next  = reload;
            phase_next         = direction ? PH_UL_ACK0 : PH_DL_RECV;
        end
        else
        begin
            case (phase_reg)
                PH_DL_RECV:
                begin
                    if (op == tcte_pkg::OP_DATA && blk != current_block_reg)
                    begin
                        // new block: ack, deliver, and finish on a short or long one
                        current_block_next = blk;
                        retries_left_next  = reload;
                        batch.res[0] = tcte_pkg::make_result(tcte_pkg::ACT_ACK, blk, 16'd0,
                                                             tcte_pkg::OUT_NONE);
                        batch.res[1] = tcte_pkg::make_result(tcte_pkg::ACT_DELIVER, blk, len,
                                                             tcte_pkg::OUT_NONE);
                        batch.count  = 2'd2;
                        if (len != full_block_bytes)
                        begin
                            batch.res[2] = tcte_pkg::make_result(tcte_pkg::ACT_FINISHED,
                                                                 16'd0, 16'd0,
                                                                 tcte_pkg::OUT_NONE);
                            batch.count  = 2'd3;
                            phase_next   = PH_DONE;
                        end
                    end
                    else if (op inside {tcte_pkg::OP_DATA, tcte_pkg::OP_TIMEOUT})
                    begin
                        // repeat or timeout: re-ack the last block and use up a retry
                        batch.res[0] = tcte_pkg::make_result(tcte_pkg::ACT_ACK,
                                                             current_block_reg, 16'd0,
                                                             tcte_pkg::OUT_NONE);
                        retries_left_next = retries_dec;
                        if (retries_dec == 4'd0)
                        begin
                            batch.res[1] = tcte_pkg::make_result(tcte_pkg::ACT_FINISHED,
                                                                 16'd0, 16'd0,
                                                                 tcte_pkg::OUT_RETRIES);
                            batch.count  = 2'd2;
                            phase_next   = PH_DONE;
                        end
                    end
                    else if (op == tcte_pkg::OP_SOCKERR)
                    begin
                        batch.res[0] = tcte_pkg::make_result(tcte_pkg::ACT_FAILED, 16'd0,
                                                             16'd0, tcte_pkg::OUT_SOCKERR);
                        phase_next   = PH_FAILED;
                    end
                end
                PH_UL_ACK0:
                begin
                    if (op == tcte_pkg::OP_ACK && blk == 16'd0)
                    begin
                        phase_next = PH_UL_CHUNK;
                    end
                    else if (op inside {tcte_pkg::OP_ACK, tcte_pkg::OP_TIMEOUT})
                    begin
                        batch.res[0] = tcte_pkg::make_result(tcte_pkg::ACT_FAILED, 16'd0,
                                                             16'd0, tcte_pkg::OUT_BADACK0);
                        phase_next   = PH_FAILED;
                    end
                    else if (op == tcte_pkg::OP_SOCKERR)
                    begin
                        batch.res[0] = tcte_pkg::make_result(tcte_pkg::ACT_FAILED, 16'd0,
                                                             16'd0, tcte_pkg::OUT_SOCKERR);
                        phase_next   = PH_FAILED;
                    end
                end
                PH_UL_CHUNK:
                begin
                    if (op == tcte_pkg::OP_CHUNK)
                    begin
                        current_block_next = next_block;
                        chunk_length_next  = len;
                        chunk_is_full_next = (len == full_block_bytes);
                        retries_left_next  = reload;
                        resend_enable_next = 1'b1;
                        batch.res[0] = tcte_pkg::make_result(tcte_pkg::ACT_DATA, next_block,
                                                             len, tcte_pkg::OUT_NONE);
                        phase_next   = PH_UL_ACK;
                    end
                    else if (op == tcte_pkg::OP_SOCKERR)
                    begin
                        batch.res[0] = tcte_pkg::make_result(tcte_pkg::ACT_ERROR, 16'd0,
                                                             16'd0, tcte_pkg::OUT_SOCKERR);
                        batch.res[1] = tcte_pkg::make_result(tcte_pkg::ACT_FAILED, 16'd0,
                                                             16'd0, tcte_pkg::OUT_SOCKERR);
                        batch.count  = 2'd2;
                        phase_next   = PH_FAILED;
                    end
                end
                PH_UL_ACK:
                begin
                    if (op == tcte_pkg::OP_ACK && blk != prev_block)
                    begin
                        resend_enable_next = 1'b1;
                        if (chunk_is_full_reg)
                        begin
                            phase_next = PH_UL_CHUNK;
                        end
                        else
                        begin
                            batch.res[0] = tcte_pkg::make_result(tcte_pkg::ACT_FINISHED,
                                                                 16'd0, 16'd0,
                                                                 tcte_pkg::OUT_NONE);
                            phase_next   = PH_DONE;
                        end
                    end
                    else if (op inside {tcte_pkg::OP_ACK, tcte_pkg::OP_TIMEOUT})
                    begin
                        // duplicate ack holds off resends until a later ack clears it
                        if (op == tcte_pkg::OP_ACK)
                        begin
                            resend_enable_next = 1'b0;
                        end
                        retries_left_next = retries_dec;
                        if (retries_dec == 4'd0)
                        begin
                            batch.res[0] = tcte_pkg::make_result(tcte_pkg::ACT_ERROR, 16'd0,
                                                                 16'd0,
                                                                 tcte_pkg::OUT_RETRIES);
                            batch.res[1] = tcte_pkg::make_result(tcte_pkg::ACT_FAILED, 16'd0,
                                                                 16'd0,
                                                                 tcte_pkg::OUT_RETRIES);
                            batch.count  = 2'd2;
                            phase_next   = PH_FAILED;
                        end
                        else if (op == tcte_pkg::OP_TIMEOUT && resend_enable_reg)
                        begin
                            batch.res[0] = tcte_pkg::make_result(tcte_pkg::ACT_DATA,
                                                                 current_block_reg,
                                                                 chunk_length_reg,
                                                                 tcte_pkg::OUT_NONE);
                        end
                    end
                    else if (op == tcte_pkg::OP_SOCKERR)
                    begin
                        batch.res[0] = tcte_pkg::make_result(tcte_pkg::ACT_ERROR, 16'd0,
                                                             16'd0, tcte_pkg::OUT_SOCKERR);
                        batch.res[1] = tcte_pkg::make_result(tcte_pkg::ACT_FAILED, 16'd0,
                                                             16'd0, tcte_pkg::OUT_SOCKERR);
                        batch.count  = 2'd2;
                        phase_next   = PH_FAILED;
                    end
                end
                default:
                begin
                    // idle, done and failed ignore everything but start
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            current_block_reg <= 16'd0;
            retries_left_reg  <= 4'd0;
            resend_enable_reg <= 1'b1;
            chunk_is_full_reg <= 1'b1;
            chunk_length_reg  <= 16'd0;
        end
        else if (fire)
        begin
            phase_reg         <= phase_next;
            current_block_reg <= current_block_next;
            retries_left_reg  <= retries_left_next;
            resend_enable_reg <= resend_enable_next;
            chunk_is_full_reg <= chunk_is_full_next;
            chunk_length_reg  <= chunk_length_next;
        end
    end

    a_start_reloads: assert property (@(posedge clk) disable iff (!rst_n)
        fire && op == tcte_pkg::OP_START |=> retries_left_reg != 4'd0)
        else $error("start left no retries");

    a_none_alone: assert property (@(posedge clk) disable iff (!rst_n)
        fire && batch.res[0].action == tcte_pkg::ACT_NONE |-> batch.count == 2'd1)
        else $error("none result not alone in batch");

    a_active_retries: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DL_RECV || phase_reg == PH_UL_ACK) |-> retries_left_reg != 4'd0)
        else $error("active phase with no retries left");

endmodule

`default_nettype wire

// ----- design/tcte_out_slot.sv -----
// tcte_out_slot: result register holding one batch and handing out its words in order.
// Depends on tcte_pkg.
`default_nettype none

module tcte_out_slot (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire tcte_pkg::batch_t  batch,
    input  wire logic              out_stall,
    output logic                   can_load,
    output logic                   out_valid,
    output tcte_pkg::result_t      word,
    output logic                   word_last
);

    logic             full_reg, full_next;
    logic [1:0]       idx_reg, idx_next;
    tcte_pkg::batch_t batch_reg;
    logic             pop;

    assign out_valid = full_reg;
    assign word      = batch_reg.res[idx_reg];
    assign word_last = (idx_reg == batch_reg.count - 2'd1);
    assign pop       = full_reg && !out_stall;
    // free now, or the last word leaves this cycle
    assign can_load  = !full_reg || (pop && word_last);

    always_comb
    begin
        full_next = full_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            full_next = 1'b1;
            idx_next  = 2'd0;
        end
        else if (pop)
        begin
            if (word_last)
            begin
                full_next = 1'b0;
                idx_next  = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            full_reg <= full_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            batch_reg <= batch;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (batch_reg.count != 2'd0 && idx_reg < batch_reg.count))
        else $error("word index outside batch");

    a_load_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("batch loaded over undelivered words");

    a_batch_continues: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !word_last |=> full_reg && idx_reg == $past(idx_reg) + 2'd1)
        else $error("batch dropped before its last word");

endmodule

`default_nettype wire

// ----- design/tftp_client_transfer_engine.sv -----
// tftp_client_transfer_engine: lock-step TFTP block-transfer controller, top level.
// Instantiates tcte_fsm and tcte_out_slot; depends on tcte_pkg.
//
//   channel   signals                                          flow control
//   -------   ----------------------------------------------   ------------------
//   in        in_valid, op, block, length                      in_stall from here
//   out       out_valid, action, out_block, out_length,
//             outcome, last                                    out_stall to here
//   cfg       cfg_write, cfg_index, cfg_data                   none, always taken
//
// An accepted event lands in the input register; once the result register can take
// the batch, the state update runs and its one to three result words are loaded there.
// Words leave one per cycle while out_stall is low, so an event's results leave in turn
// (one for most events, at most three); the result register's single read port sets this.
// An event is taken while the previous batch's last word is leaving.
// Reset restores the transfer state and the configuration and clears both valid flags.
// Hold in_stall while the input register waits for the result register to drain.
`default_nettype none

module tftp_client_transfer_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  op,
    input  wire logic [15:0] block,
    input  wire logic [15:0] length,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       action,
    output logic [15:0]      out_block,
    output logic [15:0]      out_length,
    output logic [1:0]       outcome,
    output logic             last,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // configuration registers
    logic        direction_reg;
    logic [3:0]  max_retries_reg;
    logic [15:0] full_block_bytes_reg;

    // input register
    logic        in_full_reg, in_full_next;
    logic [2:0]  op_reg;
    logic [15:0] block_reg;
    logic [15:0] length_reg;

    logic              accept;
    logic              fire;
    logic              can_load;
    tcte_pkg::batch_t  batch;
    tcte_pkg::result_t word;

    // advance the held event once the result register can take its batch
    assign fire     = in_full_reg && can_load;
    assign in_stall = in_full_reg && !can_load;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (fire)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg          <= 1'b0;
            direction_reg        <= tcte_pkg::DIRECTION_RST;
            max_retries_reg      <= tcte_pkg::MAX_RETRY_RST;
            full_block_bytes_reg <= tcte_pkg::FULL_BYTES_RST;
        end
        else
        begin
            in_full_reg <= in_full_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    tcte_pkg::CFG_DIRECTION:  direction_reg        <= cfg_data[0];
                    tcte_pkg::CFG_MAX_RETRY:  max_retries_reg      <= cfg_data[3:0];
                    tcte_pkg::CFG_FULL_BYTES: full_block_bytes_reg <= cfg_data;
                    default:
                    begin
                        // drop writes to unused indexes
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            block_reg  <= block;
            length_reg <= length;
        end
    end

    tcte_fsm u_fsm (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .op               (op_reg),
        .blk              (block_reg),
        .len              (length_reg),
        .direction        (direction_reg),
        .max_retries      (max_retries_reg),
        .full_block_bytes (full_block_bytes_reg),
        .batch            (batch)
    );

    tcte_out_slot u_out_slot (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .batch     (batch),
        .out_stall (out_stall),
        .can_load  (can_load),
        .out_valid (out_valid),
        .word      (word),
        .word_last (last)
    );

    assign action     = word.action;
    assign out_block  = word.blk;
    assign out_length = word.len;
    assign outcome    = word.outcome;

    a_stall_means_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_full_reg && out_valid)
        else $error("input stalled with nothing waiting");

    a_held_event_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_full_reg && $stable(op_reg) && $stable(block_reg))
        else $error("held event lost while stalled");

    a_fire_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("event processed without a result word");

endmodule

`default_nettype wire

// ----- tb/tftp_client_transfer_engine_test.sv -----
// Self-checking testbench for tftp_client_transfer_engine: directed and random packet events.
// Expected result words come from a behavioural model of the lock-step transfer.
// Depends on tcte_pkg and the tftp_client_transfer_engine RTL.
`default_nettype none

module tftp_client_transfer_engine_test;

    localparam int LIMIT_CYCLES = 200000;
    localparam int WORDS_PER_PHASE = 36;
    localparam int RANDOM_PHASES = 8;

    // Transfer phases tracked by the model
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DL_RECV,
        PH_UL_ACK0,
        PH_UL_CHUNK,
        PH_UL_ACK,
        PH_DONE,
        PH_FAILED
    } xfer_phase_t;

    // One expected result word with its end-of-batch mark
    typedef struct packed {
        tcte_pkg::result_t res;
        logic              last;
    } tx_word_t;

    // Behavioural model of the transfer plus the queue of result words it owes
    class lockstep_transfer;
        logic        cfg_upload;
        logic [3:0]  cfg_retries;
        logic [15:0] cfg_full;

        xfer_phase_t phase;
        logic [15:0] cur_blk;
        logic [3:0]  retries_left;
        logic        resend_en;
        logic        chunk_full;
        logic [15:0] chunk_len;

        tx_word_t due_words[$];
        int       errors;

        function new();
            cfg_upload   = tcte_pkg::DIRECTION_RST;
            cfg_retries  = tcte_pkg::MAX_RETRY_RST;
            cfg_full     = tcte_pkg::FULL_BYTES_RST;
            phase        = PH_IDLE;
            cur_blk      = 16'd0;
            retries_left = 4'd0;
            resend_en    = 1'b1;
            chunk_full   = 1'b1;
            chunk_len    = 16'd0;
            errors       = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                tcte_pkg::CFG_DIRECTION:  cfg_upload  = val[0];
                tcte_pkg::CFG_MAX_RETRY:  cfg_retries = val[3:0];
                tcte_pkg::CFG_FULL_BYTES: cfg_full    = val;
                default: ;
            endcase
        endfunction

        function int due_count();
            return due_words.size();
        endfunction

        // A retry limit of zero behaves as one
        function logic [3:0] reload_count();
            return (cfg_retries == 4'd0) ? 4'd1 : cfg_retries;
        endfunction

        function void emit(logic [2:0] act, logic [15:0] b, logic [15:0] l, logic [1:0] oc);
            tx_word_t w;
            w.res  = tcte_pkg::make_result(act, b, l, oc);
            w.last = 1'b0;
            due_words.push_back(w);
        endfunction

        // Advance the model by one accepted event; return 1 if it was not merely ignored
        function bit take_event(logic [2:0] op, logic [15:0] blk, logic [15:0] len);
            int        n_before;
            int        n_made;
            logic [7:0] snap;
            tx_word_t  w;
            n_before = due_words.size();
            snap = {phase, retries_left, resend_en};
            if (op == tcte_pkg::OP_START) begin
                cur_blk      = 16'd0;
                resend_en    = 1'b1;
                chunk_full   = 1'b1;
                chunk_len    = 16'd0;
                retries_left = reload_count();
                phase        = cfg_upload ? PH_UL_ACK0 : PH_DL_RECV;
            end else begin
                case (phase)
                    PH_DL_RECV: begin
                        if (op == tcte_pkg::OP_DATA && blk != cur_blk) begin
                            cur_blk      = blk;
                            retries_left = reload_count();
                            emit(tcte_pkg::ACT_ACK, blk, 16'd0, tcte_pkg::OUT_NONE);
                            emit(tcte_pkg::ACT_DELIVER, blk, len, tcte_pkg::OUT_NONE);
                            if (len != cfg_full) begin
                                emit(tcte_pkg::ACT_FINISHED, 16'd0, 16'd0,
                                     tcte_pkg::OUT_NONE);
                                phase = PH_DONE;
                            end
                        end else if (op == tcte_pkg::OP_DATA ||
                                     op == tcte_pkg::OP_TIMEOUT) begin
                            emit(tcte_pkg::ACT_ACK, cur_blk, 16'd0, tcte_pkg::OUT_NONE);
                            retries_left = retries_left - 4'd1;
                            if (retries_left == 4'd0) begin
                                emit(tcte_pkg::ACT_FINISHED, 16'd0, 16'd0,
                                     tcte_pkg::OUT_RETRIES);
                                phase = PH_DONE;
                            end
                        end else if (op == tcte_pkg::OP_SOCKERR) begin
                            emit(tcte_pkg::ACT_FAILED, 16'd0, 16'd0, tcte_pkg::OUT_SOCKERR);
                            phase = PH_FAILED;
                        end
                    end
                    PH_UL_ACK0: begin
                        if (op == tcte_pkg::OP_ACK && blk == 16'd0) begin
                            phase = PH_UL_CHUNK;
                        end else if (op == tcte_pkg::OP_ACK ||
                                     op == tcte_pkg::OP_TIMEOUT) begin
                            emit(tcte_pkg::ACT_FAILED, 16'd0, 16'd0, tcte_pkg::OUT_BADACK0);
                            phase = PH_FAILED;
                        end else if (op == tcte_pkg::OP_SOCKERR) begin
                            emit(tcte_pkg::ACT_FAILED, 16'd0, 16'd0, tcte_pkg::OUT_SOCKERR);
                            phase = PH_FAILED;
                        end
                    end
                    PH_UL_CHUNK: begin
                        if (op == tcte_pkg::OP_CHUNK) begin
                            cur_blk      = cur_blk + 16'd1;
                            chunk_len    = len;
                            chunk_full   = (len == cfg_full);
                            retries_left = reload_count();
                            resend_en    = 1'b1;
                            emit(tcte_pkg::ACT_DATA, cur_blk, len, tcte_pkg::OUT_NONE);
                            phase = PH_UL_ACK;
                        end else if (op == tcte_pkg::OP_SOCKERR) begin
                            emit(tcte_pkg::ACT_ERROR, 16'd0, 16'd0, tcte_pkg::OUT_SOCKERR);
                            emit(tcte_pkg::ACT_FAILED, 16'd0, 16'd0, tcte_pkg::OUT_SOCKERR);
                            phase = PH_FAILED;
                        end
                    end
                    PH_UL_ACK: begin
                        // an ack for the previous block is a duplicate, any other accepts
                        if (op == tcte_pkg::OP_ACK && blk != cur_blk - 16'd1) begin
                            resend_en = 1'b1;
                            if (chunk_full) begin
                                phase = PH_UL_CHUNK;
                            end else begin
                                emit(tcte_pkg::ACT_FINISHED, 16'd0, 16'd0,
                                     tcte_pkg::OUT_NONE);
                                phase = PH_DONE;
                            end
                        end else if (op == tcte_pkg::OP_ACK ||
                                     op == tcte_pkg::OP_TIMEOUT) begin
                            if (op == tcte_pkg::OP_ACK)
                                resend_en = 1'b0;
                            retries_left = retries_left - 4'd1;
                            if (retries_left == 4'd0) begin
                                emit(tcte_pkg::ACT_ERROR, 16'd0, 16'd0,
                                     tcte_pkg::OUT_RETRIES);
                                emit(tcte_pkg::ACT_FAILED, 16'd0, 16'd0,
                                     tcte_pkg::OUT_RETRIES);
                                phase = PH_FAILED;
                            end else if (op == tcte_pkg::OP_TIMEOUT && resend_en) begin
                                emit(tcte_pkg::ACT_DATA, cur_blk, chunk_len,
                                     tcte_pkg::OUT_NONE);
                            end
                        end else if (op == tcte_pkg::OP_SOCKERR) begin
                            emit(tcte_pkg::ACT_ERROR, 16'd0, 16'd0, tcte_pkg::OUT_SOCKERR);
                            emit(tcte_pkg::ACT_FAILED, 16'd0, 16'd0, tcte_pkg::OUT_SOCKERR);
                            phase = PH_FAILED;
                        end
                    end
                    default: ;
                endcase
            end
            n_made = due_words.size() - n_before;
            if (n_made == 0)
                emit(tcte_pkg::ACT_NONE, 16'd0, 16'd0, tcte_pkg::OUT_NONE);
            // mark the final word of the batch
            w = due_words.pop_back();
            w.last = 1'b1;
            due_words.push_back(w);
            return (op == tcte_pkg::OP_START) || (n_made != 0) ||
                   (snap != {phase, retries_left, resend_en});
        endfunction

        function void report_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        // Compare an accepted result word against the oldest one owed
        function void match_word(logic [2:0] act, logic [15:0] b, logic [15:0] l,
                                 logic [1:0] oc, logic lst);
            tx_word_t w;
            if (due_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, got action %0d block %0d",
                         $time, act, b);
                return;
            end
            w = due_words.pop_front();
            report_field("action", 16'(w.res.action), 16'(act));
            report_field("out_block", w.res.blk, b);
            report_field("out_length", w.res.len, l);
            report_field("outcome", 16'(w.res.outcome), 16'(oc));
            report_field("last", 16'(w.last), 16'(lst));
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  op = tcte_pkg::OP_START;
    logic [15:0] block = 16'd0;
    logic [15:0] length = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  action;
    logic [15:0] out_block;
    logic [15:0] out_length;
    logic [1:0]  outcome;
    logic        last;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = tcte_pkg::CFG_DIRECTION;
    logic [15:0] cfg_data = 16'd0;

    int unsigned cycle_count = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;

    lockstep_transfer sb = new();

    tftp_client_transfer_engine uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .block      (block),
        .length     (length),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .action     (action),
        .out_block  (out_block),
        .out_length (out_length),
        .outcome    (outcome),
        .last       (last),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Abort a hung run
    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("FAIL");
        $finish;
    end

    // Receiver: stall at random on the falling edge, check words on the rising edge
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.match_word(action, out_block, out_length, outcome, last);
    end

    // Present one event, idling beforehand at random, and hold it until it is taken
    task automatic send_event(input logic [2:0] op_i, input logic [15:0] blk_i,
                              input logic [15:0] len_i, output bit took);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_i;
        block    <= blk_i;
        length   <= len_i;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        took = sb.take_event(op_i, blk_i, len_i);
    endtask

    task automatic post(input logic [2:0] op_i, input logic [15:0] blk_i,
                        input logic [15:0] len_i);
        bit took;
        send_event(op_i, blk_i, len_i, took);
    endtask

    // Drop valid and wait until every owed word has come back, then let the block settle
    task automatic drain_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.due_count() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Mostly a full block, sometimes any length at all
    function automatic logic [15:0] pick_len();
        return ($urandom_range(99) < 80) ? sb.cfg_full : 16'($urandom);
    endfunction

    // Choose the next event from the current phase so that transfers run deep;
    // the remainder is noise with any op and any content
    function automatic void pick_event(output logic [2:0] op_o, output logic [15:0] blk_o,
                                       output logic [15:0] len_o);
        int unsigned roll;
        roll  = $urandom_range(99);
        op_o  = 3'($urandom_range(7));
        blk_o = 16'($urandom);
        len_o = 16'($urandom);
        case (sb.phase)
            PH_DL_RECV: begin
                if (roll < 60) begin
                    op_o  = tcte_pkg::OP_DATA;
                    blk_o = ($urandom_range(99) < 85) ? sb.cur_blk + 16'd1 : 16'($urandom);
                    len_o = pick_len();
                end else if (roll < 70) begin
                    op_o  = tcte_pkg::OP_DATA;
                    blk_o = sb.cur_blk;
                end else if (roll < 82) begin
                    op_o = tcte_pkg::OP_TIMEOUT;
                end else if (roll < 86) begin
                    op_o = tcte_pkg::OP_SOCKERR;
                end
            end
            PH_UL_ACK0: begin
                if (roll < 78) begin
                    op_o  = tcte_pkg::OP_ACK;
                    blk_o = 16'd0;
                end else if (roll < 84) begin
                    op_o = tcte_pkg::OP_ACK;
                end else if (roll < 90) begin
                    op_o = tcte_pkg::OP_TIMEOUT;
                end else if (roll < 93) begin
                    op_o = tcte_pkg::OP_SOCKERR;
                end
            end
            PH_UL_CHUNK: begin
                if (roll < 80) begin
                    op_o  = tcte_pkg::OP_CHUNK;
                    len_o = pick_len();
                end else if (roll < 84) begin
                    op_o = tcte_pkg::OP_SOCKERR;
                end
            end
            PH_UL_ACK: begin
                if (roll < 62) begin
                    op_o = tcte_pkg::OP_ACK;
                    if ($urandom_range(99) < 80)
                        blk_o = sb.cur_blk;
                end else if (roll < 76) begin
                    op_o  = tcte_pkg::OP_ACK;
                    blk_o = sb.cur_blk - 16'd1;
                end else if (roll < 90) begin
                    op_o = tcte_pkg::OP_TIMEOUT;
                end else if (roll < 93) begin
                    op_o = tcte_pkg::OP_SOCKERR;
                end
            end
            default: begin
                if (roll < 80)
                    op_o = tcte_pkg::OP_START;
            end
        endcase
    endfunction

    initial
    begin
        logic [2:0]  r_op;
        logic [15:0] r_blk;
        logic [15:0] r_len;
        bit          took;
        int          taken;
        logic [15:0] full_val;
        logic [3:0]  retry_val;

        // hold reset, then release it on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: download under the reset configuration. Ignored op, duplicate
        // block, timeout, top block number, then an over-long block ends it.
        post(3'd7, 16'h1234, 16'hFFFF);
        post(tcte_pkg::OP_START, 16'd0, 16'd0);
        post(tcte_pkg::OP_DATA, 16'd0, 16'd512);
        post(tcte_pkg::OP_DATA, 16'd1, 16'd512);
        post(tcte_pkg::OP_TIMEOUT, 16'd0, 16'd0);
        post(tcte_pkg::OP_DATA, 16'hFFFF, 16'd512);
        post(tcte_pkg::OP_DATA, 16'd7, 16'd65464);

        // Upload with a zero retry limit: bad first ack, then a duplicate ack
        // uses up the only attempt
        drain_idle();
        write_reg(tcte_pkg::CFG_DIRECTION, 16'd1);
        write_reg(tcte_pkg::CFG_MAX_RETRY, 16'd0);
        write_reg(tcte_pkg::CFG_FULL_BYTES, 16'd65464);
        post(tcte_pkg::OP_START, 16'd0, 16'd0);
        post(tcte_pkg::OP_ACK, 16'd5, 16'd0);
        post(tcte_pkg::OP_START, 16'd0, 16'd0);
        post(tcte_pkg::OP_ACK, 16'd0, 16'd0);
        post(tcte_pkg::OP_CHUNK, 16'd0, 16'd65464);
        post(tcte_pkg::OP_ACK, 16'd0, 16'd0);

        // Upload with the largest retry limit: resend on timeout, hold after a
        // duplicate ack, accept, then a socket error
        drain_idle();
        write_reg(tcte_pkg::CFG_MAX_RETRY, 16'd15);
        write_reg(tcte_pkg::CFG_FULL_BYTES, 16'd1);
        post(tcte_pkg::OP_START, 16'd0, 16'd0);
        post(tcte_pkg::OP_ACK, 16'd0, 16'd0);
        post(tcte_pkg::OP_CHUNK, 16'd0, 16'd1);
        post(tcte_pkg::OP_TIMEOUT, 16'd0, 16'd0);
        post(tcte_pkg::OP_ACK, 16'd0, 16'd0);
        post(tcte_pkg::OP_TIMEOUT, 16'd0, 16'd0);
        post(tcte_pkg::OP_ACK, 16'd1, 16'd0);
        post(tcte_pkg::OP_SOCKERR, 16'd0, 16'd0);

        // Download with one attempt: out of retries, empty last block, socket error
        drain_idle();
        write_reg(tcte_pkg::CFG_DIRECTION, 16'd0);
        write_reg(tcte_pkg::CFG_MAX_RETRY, 16'd1);
        post(tcte_pkg::OP_START, 16'd0, 16'd0);
        post(tcte_pkg::OP_DATA, 16'd0, 16'd1);
        post(tcte_pkg::OP_START, 16'd0, 16'd0);
        post(tcte_pkg::OP_DATA, 16'd3, 16'd0);
        post(tcte_pkg::OP_START, 16'd0, 16'd0);
        post(tcte_pkg::OP_SOCKERR, 16'd0, 16'd0);

        // Random transfers: new settings and one of four idling patterns in each phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_idle();
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 70; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 70; end
                default: begin gap_pct = 15; stall_pct = 15; end
            endcase
            case (ph)
                0: retry_val = 4'd1;
                1: retry_val = 4'd15;
                2: retry_val = 4'd0;
                default: retry_val = 4'($urandom_range(1, 15));
            endcase
            case (ph)
                0: full_val = 16'd65464;
                1: full_val = 16'd1;
                2: full_val = 16'd512;
                default: full_val = 16'($urandom_range(1, 65464));
            endcase
            write_reg(tcte_pkg::CFG_DIRECTION, {15'd0, ph[0] ^ ph[2]});
            write_reg(tcte_pkg::CFG_MAX_RETRY, {12'd0, retry_val});
            write_reg(tcte_pkg::CFG_FULL_BYTES, full_val);
            taken = 0;
            while (taken < WORDS_PER_PHASE)
            begin
                pick_event(r_op, r_blk, r_len);
                send_event(r_op, r_blk, r_len, took);
                if (took)
                    taken++;
            end
        end

        drain_idle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.due_count() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
design/tcte_pkg.sv
design/tcte_fsm.sv
design/tcte_out_slot.sv
design/tftp_client_transfer_engine.sv
tb/tftp_client_transfer_engine_test.sv
